[hdl/bhp_pkg.sv]
// Shared constants for the blink hysteresis and PERCLOS block.
`default_nettype none

package bhp_pkg;

  localparam int WINDOW_FRAMES_DEFAULT = 64;
  localparam int COUNT_BITS_DEFAULT    = 20;

  localparam int PCT_W       = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_TOTAL_W = 7;
  localparam int OUT_PCT_W   = 7;

  // Scale of the cross-multiplied threshold test and of the PERCLOS ratio.
  localparam int THRESH_SCALE = 200;
  localparam int PERCENT      = 100;

  localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_DROP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_RISE  = 2'd1;

  localparam logic [PCT_W-1:0] CLOSE_DROP_RESET = 8'd80;
  localparam logic [PCT_W-1:0] OPEN_RISE_RESET  = 8'd20;

endpackage : bhp_pkg

`default_nettype wire

[hdl/blink_hysteresis_perclos_top.sv]
// A frame count passes through the input register and then the result register.
// Throughput: one frame count per cycle while out_ready does not hold the output;
// the hysteresis compare and the window update are combinational between the two registers.
// The closed-frame window is a WINDOW_FRAMES-deep shift line of flags.
// Reset (rst, synchronous): eye open, window empty, PERCLOS 0, thresholds 80 and 20.
// The block is ready for transactions as soon as reset drops (in_ready and cfg_ready follow !rst).
`default_nettype none

module blink_hysteresis_perclos_top #(
  parameter int WINDOW_FRAMES = bhp_pkg::WINDOW_FRAMES_DEFAULT,
  parameter int COUNT_BITS    = bhp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bhp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bhp_pkg::PCT_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [COUNT_BITS-1:0]            dark_pixel_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  eye_closed,
  output logic [bhp_pkg::OUT_TOTAL_W-1:0]       closed_in_window,
  output logic [bhp_pkg::OUT_PCT_W-1:0]         perclos_pct,
  output logic                                  window_full
);

  import bhp_pkg::*;

  localparam int PROD_W  = COUNT_BITS + 9;
  localparam int TOTAL_W = $clog2(WINDOW_FRAMES + 1);
  localparam int FRAME_W = $clog2(WINDOW_FRAMES + 1);
  localparam int REM_W   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int Q_STEP  = PERCENT / WINDOW_FRAMES;
  localparam int R_STEP  = PERCENT % WINDOW_FRAMES;

  localparam logic [OUT_PCT_W-1:0] Q_STEP_V  = OUT_PCT_W'(Q_STEP);
  localparam logic [REM_W:0]       R_STEP_V  = (REM_W + 1)'(R_STEP);
  localparam logic [REM_W:0]       WINDOW_V  = (REM_W + 1)'(WINDOW_FRAMES);
  localparam logic [FRAME_W-1:0]   FULL_V    = FRAME_W'(WINDOW_FRAMES);
  localparam logic [PROD_W-1:0]    SCALE_V   = PROD_W'(THRESH_SCALE);

  // configuration
  logic [PCT_W-1:0] close_drop_pct;
  logic [PCT_W-1:0] open_rise_pct;

  // input register
  logic                  s1_valid;
  logic [COUNT_BITS-1:0] s1_count;

  // state
  logic [COUNT_BITS-1:0] previous_count;
  logic                  closed_flag;
  logic                  closed_history [WINDOW_FRAMES];
  logic [TOTAL_W-1:0]    closed_total;
  logic [FRAME_W-1:0]    frames_seen;
  logic [OUT_PCT_W-1:0]  pct_quot;
  logic [REM_W-1:0]      pct_rem;

  logic                  advance;
  logic                  process;
  logic                  full;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] drop;
  logic [COUNT_BITS-1:0] rise;
  logic [PROD_W-1:0]     drop_scaled;
  logic [PROD_W-1:0]     rise_scaled;
  logic [PROD_W-1:0]     close_limit;
  logic [PROD_W-1:0]     open_limit;
  logic                  close_hit;
  logic                  open_hit;
  logic                  closed_flag_next;
  logic                  oldest;
  logic                  total_inc;
  logic                  total_dec;
  logic [TOTAL_W-1:0]    closed_total_next;
  logic [FRAME_W-1:0]    frames_seen_next;
  logic [REM_W:0]        rem_up;
  logic [REM_W:0]        rem_down;
  logic [OUT_PCT_W-1:0]  pct_quot_next;
  logic [REM_W-1:0]      pct_rem_next;

  assign cfg_ready = !rst;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !rst && (!s1_valid || advance);
  assign process   = s1_valid && advance;
  assign full      = (frames_seen == FULL_V);

  always_comb begin
    count_sum   = {1'b0, previous_count} + {1'b0, s1_count};
    drop        = previous_count - s1_count;
    rise        = s1_count - previous_count;
    drop_scaled = PROD_W'(drop) * SCALE_V;
    rise_scaled = PROD_W'(rise) * SCALE_V;
    close_limit = PROD_W'(close_drop_pct) * PROD_W'(count_sum);
    open_limit  = PROD_W'(open_rise_pct) * PROD_W'(count_sum);

    // both counts zero: hold the flag
    close_hit = (count_sum != '0) && (previous_count >= s1_count) &&
                (drop_scaled >= close_limit);
    open_hit  = (count_sum != '0) && (s1_count >= previous_count) &&
                (rise_scaled >= open_limit);

    if (close_hit) begin
      closed_flag_next = 1'b1;
    end else if (open_hit) begin
      closed_flag_next = 1'b0;
    end else begin
      closed_flag_next = closed_flag;
    end

    // drop the oldest flag only once the window is full
    oldest    = full && closed_history[WINDOW_FRAMES-1];
    total_inc = closed_flag_next && !oldest;
    total_dec = oldest && !closed_flag_next;

    closed_total_next = closed_total;
    pct_quot_next     = pct_quot;
    pct_rem_next      = pct_rem;
    rem_up            = (REM_W + 1)'(pct_rem) + R_STEP_V;
    rem_down          = (REM_W + 1)'(pct_rem) + WINDOW_V - R_STEP_V;

    // track closed_total*100 as pct_quot*WINDOW_FRAMES + pct_rem
    if (total_inc) begin
      closed_total_next = closed_total + TOTAL_W'(1);
      if (rem_up >= WINDOW_V) begin
        pct_rem_next  = REM_W'(rem_up - WINDOW_V);
        pct_quot_next = pct_quot + Q_STEP_V + OUT_PCT_W'(1);
      end else begin
        pct_rem_next  = REM_W'(rem_up);
        pct_quot_next = pct_quot + Q_STEP_V;
      end
    end else if (total_dec) begin
      closed_total_next = closed_total - TOTAL_W'(1);
      if ((REM_W + 1)'(pct_rem) < R_STEP_V) begin
        pct_rem_next  = REM_W'(rem_down);
        pct_quot_next = pct_quot - Q_STEP_V - OUT_PCT_W'(1);
      end else begin
        pct_rem_next  = REM_W'(rem_down - WINDOW_V);
        pct_quot_next = pct_quot - Q_STEP_V;
      end
    end

    frames_seen_next = full ? frames_seen : frames_seen + FRAME_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      close_drop_pct <= CLOSE_DROP_RESET;
      open_rise_pct  <= OPEN_RISE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOSE_DROP: close_drop_pct <= cfg_data;
        REG_OPEN_RISE:  open_rise_pct  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_count <= dark_pixel_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_count <= '0;
      closed_flag    <= 1'b0;
      closed_total   <= '0;
      frames_seen    <= '0;
      pct_quot       <= '0;
      pct_rem        <= '0;
    end else if (process) begin
      out_valid      <= 1'b1;
      previous_count <= s1_count;
      closed_flag    <= closed_flag_next;
      closed_total   <= closed_total_next;
      frames_seen    <= frames_seen_next;
      pct_quot       <= pct_quot_next;
      pct_rem        <= pct_rem_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // history entries are read only after all of them have been written
  always_ff @(posedge clk) begin
    if (process) begin
      closed_history[0] <= closed_flag_next;
      for (int i = 1; i < WINDOW_FRAMES; i++) begin
        closed_history[i] <= closed_history[i-1];
      end
    end
  end

  assign eye_closed       = closed_flag;
  assign closed_in_window = OUT_TOTAL_W'(closed_total);
  assign window_full      = full;
  assign perclos_pct      = full ? pct_quot : '0;

endmodule : blink_hysteresis_perclos_top

`default_nettype wire
